>>> rtl/fmss_pkg.sv
// Shared types and constants for the band survey scheduler.
// No dependencies.
`default_nettype none
package fmss_pkg;
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_TUNE   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_ROUND  = 2'd3;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SAMPLE = 3'd1;
    localparam logic [2:0] OP_SYNC   = 3'd2;
    localparam logic [2:0] OP_CLOCK  = 3'd3;
    localparam logic [2:0] OP_NAME   = 3'd4;

    localparam logic [2:0] REG_SCAN_START = 3'd0;
    localparam logic [2:0] REG_SCAN_END   = 3'd1;
    localparam logic [2:0] REG_SCAN_STEP  = 3'd2;
    localparam logic [2:0] REG_SETTLE     = 3'd3;
    localparam logic [2:0] REG_MIN_SNR    = 3'd4;
    localparam logic [2:0] REG_DWELL      = 3'd5;
    localparam logic [2:0] REG_NOSYNC     = 3'd6;
    localparam logic [2:0] REG_LINGER     = 3'd7;

    localparam logic [1:0] RSN_NONE   = 2'd0;
    localparam logic [1:0] RSN_CLOCK  = 2'd1;
    localparam logic [1:0] RSN_NOSYNC = 2'd2;
    localparam logic [1:0] RSN_TIMEOUT = 2'd3;

    localparam logic [19:0] MAX20 = 20'hFFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] channel;
        logic [5:0]  station_index;
        logic [15:0] round_number;
        logic [6:0]  ct_station_count;
        logic [1:0]  end_reason;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

>>> rtl/fm_station_survey_scheduler.sv
// Band survey scheduler top level: scan, station table and dwell sequencer.
// Depends on fmss_pkg.
// A word without result frees the input the next cycle; a sample request passes
// through the result queue and then the output register. A dwell end walks up to
// MAX_STATIONS+1 hops and counts clock marks over the table for each round done
// before its last word is queued.
// Throughput: one word at a time; the next is taken once the last result word has left.
// Reset is synchronous and active low; table contents undefined until written.
`default_nettype none
module fm_station_survey_scheduler
    import fmss_pkg::*;
#(
    parameter int MAX_STATIONS = 48
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire  [2:0]   i_opcode,
    input  wire  [6:0]   i_snr,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [1:0]   o_action,
    output logic [13:0]  o_channel,
    output logic [5:0]   o_station_index,
    output logic [15:0]  o_round_number,
    output logic [6:0]   o_ct_station_count,
    output logic [1:0]   o_end_reason,
    output logic         o_last,
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [19:0]  i_cfg_data
);
    localparam int IW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CW = $clog2(MAX_STATIONS + 1);
    localparam logic [CW-1:0] NMAX = CW'(MAX_STATIONS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_WEAK   = 4'd2;
    localparam logic [3:0] S_REPL   = 4'd3;
    localparam logic [3:0] S_RASTER = 4'd4;
    localparam logic [3:0] S_HOP    = 4'd5;
    localparam logic [3:0] S_COUNT  = 4'd6;
    localparam logic [3:0] S_ELIG   = 4'd7;
    localparam logic [3:0] S_TUNE   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_FETCH  = 4'd10;
    localparam logic [3:0] S_SAMP   = 4'd11;

    localparam logic [1:0] PH_BOOT = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_DWELL = 2'd2;

    logic [13:0] r_scan_start, r_scan_end;
    logic [9:0]  r_scan_step;
    logic [19:0] r_settle, r_dwell, r_nosync, r_linger;
    logic [6:0]  r_min_snr;

    logic [1:0]  r_phase;
    logic [13:0] r_scan_ch;
    logic [19:0] r_elapsed, r_since;
    logic [13:0] mem_ch [MAX_STATIONS];
    logic [6:0]  mem_snr [MAX_STATIONS];
    logic [MAX_STATIONS-1:0] r_had_sync, r_had_clock;
    logic        r_any_clock;
    logic [CW-1:0] r_count;
    logic [5:0]  r_cur;
    logic [15:0] r_round;
    logic [2:0]  r_flags;

    logic [3:0]  r_state;
    logic [1:0]  r_reason;
    logic [6:0]  r_snr_in;
    logic [CW-1:0] r_walk;
    logic [IW-1:0] r_weak;
    logic [6:0]  r_weak_snr;
    logic [CW:0] r_hop;
    logic [6:0]  r_ctn;
    logic        r_sample_after;
    logic [6:0]  r_rd_snr;
    logic [13:0] r_rd_ch;

    // result queue of up to three words
    t_result     r_q [3];
    logic [1:0]  r_qn;
    logic [1:0]  r_qh;
    logic        r_out_v;
    t_result     r_out;

    logic        acc;
    assign o_stall = (r_state != S_IDLE) || (r_qn != 2'd0) || r_out_v;
    assign acc = i_valid && !o_stall;

    t_result push_w;
    logic    push;
    logic    fin;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start <= 14'd8790; r_scan_end <= 14'd10790; r_scan_step <= 10'd20;
            r_settle <= 20'd180; r_min_snr <= 7'd8; r_dwell <= 20'd75000;
            r_nosync <= 20'd12000; r_linger <= 20'd4000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCAN_START: r_scan_start <= i_cfg_data[13:0];
                REG_SCAN_END:   r_scan_end   <= i_cfg_data[13:0];
                REG_SCAN_STEP:  r_scan_step  <= i_cfg_data[9:0];
                REG_SETTLE:     r_settle     <= i_cfg_data;
                REG_MIN_SNR:    r_min_snr    <= i_cfg_data[6:0];
                REG_DWELL:      r_dwell      <= i_cfg_data;
                REG_NOSYNC:     r_nosync     <= i_cfg_data;
                REG_LINGER:     r_linger     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared compare unit operands
    logic [IW-1:0] rd_addr;
    logic [14:0]   nxt_wide;
    logic          cur_ok;
    logic [IW-1:0] cur_idx;
    logic [5:0]    cur_inc;
    logic          elig;
    logic          hop_wrap;
    logic [5:0]    hop_cur;
    logic          end_clk, end_ns, end_to;
    logic [19:0]   el_n, sc_n;
    logic [2:0]    fl_n;

    assign cur_ok  = {1'b0, r_cur} < 7'(MAX_STATIONS);
    assign cur_idx = cur_ok ? r_cur[IW-1:0] : '0;
    assign nxt_wide = {1'b0, r_scan_ch} + {5'd0, r_scan_step};
    assign cur_inc = r_cur + 6'd1;
    assign hop_wrap = 7'(cur_inc) >= 7'(r_count) || r_cur == 6'd63;
    assign hop_cur = hop_wrap ? 6'd0 : cur_inc;
    always_comb begin
        if ({1'b0, r_cur} >= 7'(MAX_STATIONS)) elig = 1'b0;
        else if (r_round == 16'd1) elig = 1'b1;
        else if (r_had_clock[cur_idx]) elig = 1'b1;
        else if (!r_any_clock) elig = r_had_sync[cur_idx];
        else elig = 1'b0;
    end

    always_comb begin
        el_n = r_elapsed;
        sc_n = r_since;
        fl_n = r_flags;
        case (i_opcode)
            OP_TICK: begin
                if (r_elapsed != MAX20) el_n = r_elapsed + 20'd1;
                if (r_flags[1] && r_since != MAX20) sc_n = r_since + 20'd1;
            end
            OP_SYNC:  fl_n = r_flags | 3'b001;
            OP_CLOCK: begin fl_n = r_flags | 3'b010; sc_n = '0; end
            OP_NAME:  fl_n = r_flags | 3'b100;
            default: ;
        endcase
        end_clk = fl_n[1] && (fl_n[2] || sc_n > r_linger);
        end_ns  = !fl_n[0] && el_n > r_nosync;
        end_to  = el_n > r_dwell;
    end

    always_comb begin
        rd_addr = '0;
        case (r_state)
            S_WEAK:  rd_addr = (r_walk < NMAX) ? r_walk[IW-1:0] : '0;
            default: rd_addr = cur_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_snr <= mem_snr[rd_addr];
        r_rd_ch  <= mem_ch[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= PH_BOOT; r_scan_ch <= 14'd8790;
            r_elapsed <= '0; r_since <= '0; r_had_sync <= '0; r_had_clock <= '0;
            r_any_clock <= 1'b0; r_count <= '0; r_cur <= '0; r_round <= 16'd1;
            r_flags <= '0; r_reason <= RSN_NONE; r_walk <= '0; r_weak <= '0;
            r_weak_snr <= '0; r_hop <= '0; r_ctn <= '0; r_sample_after <= 1'b0;
            r_snr_in <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    r_snr_in <= i_snr;
                    case (r_phase)
                        PH_BOOT: begin
                            r_scan_ch <= r_scan_start;
                            r_phase <= PH_SCAN; r_elapsed <= '0;
                            r_sample_after <= (r_settle == 20'd0);
                            r_state <= S_EMIT;
                        end
                        PH_SCAN: begin
                            if (i_opcode == OP_TICK) begin
                                if (r_elapsed != MAX20) begin
                                    r_elapsed <= r_elapsed + 20'd1;
                                end
                                r_state <= S_IDLE;
                            end else if (i_opcode == OP_SAMPLE && r_elapsed >= r_settle) begin
                                r_state <= S_DECIDE;
                            end
                        end
                        default: begin
                            r_elapsed <= el_n; r_since <= sc_n; r_flags <= fl_n;
                            if (i_opcode == OP_SYNC) r_had_sync[cur_idx] <= 1'b1;
                            if (i_opcode == OP_CLOCK) begin
                                r_had_clock[cur_idx] <= 1'b1;
                                r_any_clock <= 1'b1;
                            end
                            if (end_clk || end_ns || end_to) begin
                                r_reason <= end_clk ? RSN_CLOCK :
                                            (end_ns ? RSN_NOSYNC : RSN_TIMEOUT);
                                r_hop <= '0;
                                r_state <= S_HOP;
                            end
                        end
                    endcase
                end
                S_DECIDE: begin
                    if (r_snr_in >= r_min_snr) begin
                        if (r_count < NMAX) begin
                            r_count <= r_count + 1'b1;
                            r_state <= S_RASTER;
                        end else begin
                            r_walk <= '0; r_weak <= '0;
                            r_weak_snr <= 7'h7F;
                            r_state <= S_WEAK;
                        end
                    end else r_state <= S_RASTER;
                end
                S_WEAK: begin
                    // read data for r_walk arrives next cycle, so it is taken as the entry at r_walk - 1
                    if (r_walk != '0) begin
                        if (r_rd_snr < r_weak_snr) begin
                            r_weak_snr <= r_rd_snr;
                            r_weak <= IW'(r_walk - 1'b1);
                        end
                    end
                    if (r_walk == NMAX) r_state <= S_REPL;
                    else r_walk <= r_walk + 1'b1;
                end
                S_REPL: r_state <= S_RASTER;
                S_RASTER: begin
                    if (nxt_wide > {1'b0, r_scan_end}) begin
                        if (r_count == '0) begin
                            r_scan_ch <= r_scan_start;
                            r_elapsed <= '0;
                            r_sample_after <= (r_settle == 20'd0);
                            r_state <= S_EMIT;
                        end else begin
                            r_cur <= '0; r_reason <= RSN_NONE;
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_scan_ch <= nxt_wide[13:0];
                        r_elapsed <= '0;
                        r_sample_after <= (r_settle == 20'd0);
                        r_state <= S_EMIT;
                    end
                end
                S_HOP: begin
                    r_cur <= hop_cur;
                    r_hop <= r_hop + 1'b1;
                    if (hop_wrap) begin
                        r_walk <= '0; r_ctn <= '0;
                        r_state <= S_COUNT;
                    end else r_state <= S_ELIG;
                end
                S_COUNT: begin
                    if (r_walk < r_count && r_walk < NMAX) begin
                        if (r_had_clock[r_walk[IW-1:0]]) r_ctn <= r_ctn + 7'd1;
                        r_walk <= r_walk + 1'b1;
                    end else begin
                        if (r_round != 16'hFFFF) r_round <= r_round + 16'd1;
                        r_state <= S_ELIG;
                    end
                end
                S_ELIG: begin
                    if (elig || r_hop > {1'b0, r_count}) r_state <= S_FETCH;
                    else r_state <= S_HOP;
                end
                S_FETCH: r_state <= S_TUNE;
                S_TUNE: begin
                    r_phase <= PH_DWELL; r_flags <= '0;
                    r_elapsed <= '0; r_since <= '0;
                    r_state <= S_IDLE;
                end
                S_EMIT: r_state <= r_sample_after ? S_SAMP : S_IDLE;
                S_SAMP: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && r_snr_in >= r_min_snr && r_count < NMAX) begin
            mem_ch[r_count[IW-1:0]]  <= r_scan_ch;
            mem_snr[r_count[IW-1:0]] <= r_snr_in;
        end else if (r_state == S_REPL && r_snr_in > r_weak_snr) begin
            mem_ch[r_weak]  <= r_scan_ch;
            mem_snr[r_weak] <= r_snr_in;
        end
    end

    // result words
    always_comb begin
        push = 1'b0;
        fin = 1'b0;
        push_w = '0;
        case (r_state)
            S_IDLE: if (acc && r_phase == PH_SCAN && i_opcode == OP_TICK
                        && r_elapsed != MAX20 && (r_elapsed + 20'd1) == r_settle) begin
                push = 1'b1; fin = 1'b1;
                push_w.action = ACT_SAMPLE;
            end
            S_EMIT: begin
                push = 1'b1; fin = !r_sample_after;
                push_w.action = ACT_TUNE; push_w.channel = r_scan_ch;
            end
            S_SAMP: begin
                push = 1'b1; fin = 1'b1;
                push_w.action = ACT_SAMPLE;
            end
            S_COUNT: if (!(r_walk < r_count && r_walk < NMAX)) begin
                push = 1'b1;
                push_w.action = ACT_ROUND; push_w.round_number = r_round;
                push_w.ct_station_count = r_ctn; push_w.end_reason = r_reason;
            end
            S_TUNE: begin
                push = 1'b1; fin = 1'b1;
                push_w.action = ACT_TUNE; push_w.channel = r_rd_ch;
                push_w.station_index = r_cur; push_w.end_reason = r_reason;
            end
            default: ;
        endcase
        push_w.last = fin;
    end

    logic [2:0] qsum;
    logic [1:0] qt;
    logic       pop;
    assign qsum = {1'b0, r_qh} + {1'b0, r_qn};
    assign qt = (qsum >= 3'd3) ? 2'(qsum - 3'd3) : qsum[1:0];
    assign pop = (!r_out_v || !i_stall) && r_qn != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= '0; r_qh <= '0; r_out_v <= 1'b0;
        end else begin
            if (push) r_q[qt] <= push_w;
            if (pop) begin
                r_out <= r_q[r_qh];
                r_out_v <= 1'b1;
                r_qh <= (r_qh == 2'd2) ? 2'd0 : r_qh + 2'd1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            r_qn <= r_qn + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_valid            = r_out_v;
    assign o_action           = r_out.action;
    assign o_channel          = r_out.channel;
    assign o_station_index    = r_out.station_index;
    assign o_round_number     = r_out.round_number;
    assign o_ct_station_count = r_out.ct_station_count;
    assign o_end_reason       = r_out.end_reason;
    assign o_last             = r_out.last;
endmodule
`default_nettype wire
